@@ rtl/ica_pkg.sv @@
// Shared types and constants for the image column average block.
// Holds field widths, register indexes, the controller state type and the
// command and status structs that join the controller to the datapath.
package ica_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int AVG_W       = 16;
    localparam int COL_IDX_W   = 13;
    localparam int SUM_W       = 28;
    localparam int WIDTH_W     = 14;
    localparam int EPP_W       = 3;
    localparam int LCNT_W      = 13;
    localparam int LEN_W       = 17;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_CNT_W   = $clog2(SUM_W);
    localparam int OUT_DATA_W  = 32;

    localparam int DEF_MAX_LINE  = 8192;
    localparam int DEF_MAX_LINES = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PIXELS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENTS_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT         = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } ica_state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_start;
        logic emit;
    } ica_cmd_t;

    typedef struct packed {
        logic cfg_bad;
        logic last_line;
        logic div_done;
        logic div_busy;
        logic out_free;
    } ica_status_t;

endpackage

@@ rtl/image_column_average.sv @@
// Image column average. A word not on the last line is accepted, then the
// read-modify-write of its column sum follows. A last-line word also runs the 28-step divider;
// its result is emitted once the divider is done. Error words go straight from accept to emit.
// The output register lets a new word be accepted while a result waits on m_tready.
// rst_n clears positions, configuration (all registers to 1) and control state at once;
// the column sum memory is not cleared, since line zero of each frame writes it first.
module image_column_average
    import ica_pkg::*;
#(
    parameter int MAX_LINE  = DEF_MAX_LINE,
    parameter int MAX_LINES = DEF_MAX_LINES
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration writes: index 0 width_pixels, 1 elements_per_pixel, 2 line_count.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
    input  logic                  s_tuser,   // [0] start_of_frame

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [12:0] column_index, [28:13] column_average
    output logic                  m_tlast,   // last_column
    output logic                  m_tuser    // [0] config_error
);

    ica_cmd_t    cmd;
    ica_status_t status;

    // The controller only sequences; every stored value but its state lives in the datapath.
    ica_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the column sum memory, the positions and the divider.
    ica_datapath #(
        .MAX_LINE  (MAX_LINE),
        .MAX_LINES (MAX_LINES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // One word at a time: the cycle after an accept is always spent on that word.
    a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while the previous one was still in work");

    // A result is only loaded when the output register is empty or draining.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // The divider is never restarted while it is still iterating.
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    // An error result carries no column, no average and no last mark.
    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
        else $error("error result with nonzero fields");

endmodule

@@ rtl/ica_divider.sv @@
// Iterative restoring divider: one quotient bit per cycle.
// Depends on ica_pkg for the sum and line count widths.
module ica_divider
    import ica_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [LCNT_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [AVG_W-1:0]  quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [LCNT_W-1:0]    rem_reg;
    logic [LCNT_W-1:0]    dsr_reg;

    logic [LCNT_W:0]      trial;
    logic [LCNT_W+1:0]    diff;
    logic                 q_bit;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign q_bit = !diff[LCNT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(SUM_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[LCNT_W-1:0] : trial[LCNT_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg[AVG_W-1:0];

endmodule

@@ rtl/ica_datapath.sv @@
// Datapath: configuration registers, position counters, column sum memory,
// the divider and the output register. Depends on ica_pkg and ica_divider.
module ica_datapath
    import ica_pkg::*;
#(
    parameter int MAX_LINE  = DEF_MAX_LINE,
    parameter int MAX_LINES = DEF_MAX_LINES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SAMPLE_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  ica_cmd_t              cmd,
    output ica_status_t           status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    localparam int COL_W  = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    logic [WIDTH_W-1:0]  width_reg;
    logic [EPP_W-1:0]    epp_reg;
    logic [LCNT_W-1:0]   lcnt_reg;

    logic [COL_W-1:0]    col_pos_reg, col_pos_next;
    logic [LINE_W-1:0]   line_pos_reg, line_pos_next;

    logic [COL_W-1:0]    item_col_reg;
    logic [LINE_W-1:0]   item_line_reg;
    logic [SAMPLE_W-1:0] item_sample_reg;
    logic                item_err_reg;

    logic [SUM_W-1:0]    sum_mem [MAX_LINE];
    logic [SUM_W-1:0]    rd_reg;

    logic                out_valid_reg;
    logic [COL_IDX_W-1:0] out_col_reg;
    logic [AVG_W-1:0]    out_avg_reg;
    logic                out_last_reg;
    logic                out_err_reg;

    logic [LEN_W-1:0]    line_len;
    logic [LEN_W-1:0]    lcnt_ext;
    logic [COL_W-1:0]    col_base, col_eff;
    logic [LINE_W-1:0]   line_base, line_eff;
    logic [LEN_W-1:0]    col_inc_ext, line_inc_ext, col_ext;
    logic                wrap_col;
    logic [SUM_W-1:0]    sum_upd;
    logic                div_busy, div_done;
    logic [AVG_W-1:0]    quotient;

    assign line_len = LEN_W'(width_reg) * LEN_W'(epp_reg);
    assign lcnt_ext = LEN_W'(lcnt_reg);

    assign status.cfg_bad = (line_len == '0) || (line_len > LEN_W'(MAX_LINE)) ||
                            (lcnt_reg == '0) || (lcnt_ext > LEN_W'(MAX_LINES));

    // Positions seen by the arriving word: start of frame clears them, and a
    // position left out of range by a register change restarts at zero.
    assign col_base  = s_tuser ? '0 : col_pos_reg;
    assign line_base = s_tuser ? '0 : line_pos_reg;
    assign col_eff   = (LEN_W'(col_base) >= line_len) ? '0 : col_base;
    assign line_eff  = (LEN_W'(line_base) >= lcnt_ext) ? '0 : line_base;

    assign col_inc_ext  = LEN_W'(item_col_reg) + LEN_W'(1);
    assign line_inc_ext = LEN_W'(item_line_reg) + LEN_W'(1);
    assign col_ext      = LEN_W'(item_col_reg);
    assign wrap_col     = (col_inc_ext == line_len);

    assign status.last_line = (line_inc_ext == lcnt_ext);

    always_comb
    begin
        col_pos_next  = wrap_col ? '0 : col_inc_ext[COL_W-1:0];
        line_pos_next = item_line_reg;
        if (wrap_col)
        begin
            line_pos_next = status.last_line ? '0 : line_inc_ext[LINE_W-1:0];
        end
    end

    assign sum_upd = (item_line_reg == '0) ? SUM_W'(item_sample_reg)
                                           : rd_reg + SUM_W'(item_sample_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_W'(1);
            epp_reg   <= EPP_W'(1);
            lcnt_reg  <= LCNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH_PIXELS:       width_reg <= cfg_data[WIDTH_W-1:0];
                REG_ELEMENTS_PER_PIXEL: epp_reg   <= cfg_data[EPP_W-1:0];
                REG_LINE_COUNT:         lcnt_reg  <= cfg_data[LCNT_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            line_pos_reg <= '0;
        end
        else if (cmd.update)
        begin
            col_pos_reg  <= col_pos_next;
            line_pos_reg <= line_pos_next;
        end
        else if (cmd.accept && s_tuser)
        begin
            col_pos_reg  <= '0;
            line_pos_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_col_reg    <= col_eff;
            item_line_reg   <= line_eff;
            item_sample_reg <= s_tdata;
            item_err_reg    <= status.cfg_bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_reg <= sum_mem[col_eff];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            sum_mem[item_col_reg] <= sum_upd;
        end
    end

    ica_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_upd),
        .divisor  (lcnt_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_col_reg  <= item_err_reg ? '0 : col_ext[COL_IDX_W-1:0];
            out_avg_reg  <= item_err_reg ? '0 : quotient;
            out_last_reg <= item_err_reg ? 1'b0 : wrap_col;
            out_err_reg  <= item_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - COL_IDX_W - AVG_W){1'b0}}, out_avg_reg, out_col_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

@@ rtl/ica_ctrl.sv @@
// Controller state machine: sequences accept, sum update, divide and emit.
// Depends on ica_pkg for the state type and the command and status structs.
module ica_ctrl
    import ica_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  ica_status_t status,
    output ica_cmd_t    cmd
);

    ica_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.cfg_bad ? ST_EMIT : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = status.last_line ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.div_start = status.last_line;
            end
            ST_DIVIDE:
            begin
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule
